@@ hdl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Holds the beat structs, token kind codes, scan modes and keyword lookup.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int OffsetBits = 24;
    localparam int LineBits   = 20;
    localparam int ColumnBits = 16;
    localparam int KeywordLen = 8;
    localparam int NestMax    = 255;
    localparam int DepthBits  = $clog2(NestMax + 1);
    localparam int KindBits   = 7;
    localparam int ModeBits   = 5;
    localparam int PrefixBits = 64;
    localparam int LenBits    = $clog2(KeywordLen + 1);

    localparam logic [OffsetBits-1:0] OFF_MAX = '1;
    localparam logic [LineBits-1:0]   LIN_MAX = '1;
    localparam logic [ColumnBits-1:0] COL_MAX = '1;

    // token kinds
    localparam logic [KindBits-1:0] K_EOF      = 7'd0;
    localparam logic [KindBits-1:0] K_IDENT    = 7'd1;
    localparam logic [KindBits-1:0] K_INT      = 7'd2;
    localparam logic [KindBits-1:0] K_FLOAT    = 7'd3;
    localparam logic [KindBits-1:0] K_STRING   = 7'd4;
    localparam logic [KindBits-1:0] K_CHAR     = 7'd5;
    localparam logic [KindBits-1:0] K_ASSIGN   = 7'd7;
    localparam logic [KindBits-1:0] K_CASSIGN  = 7'd8;
    localparam logic [KindBits-1:0] K_EQ       = 7'd9;
    localparam logic [KindBits-1:0] K_EQEQ     = 7'd10;
    localparam logic [KindBits-1:0] K_NE       = 7'd11;
    localparam logic [KindBits-1:0] K_LT       = 7'd12;
    localparam logic [KindBits-1:0] K_LE       = 7'd13;
    localparam logic [KindBits-1:0] K_GT       = 7'd14;
    localparam logic [KindBits-1:0] K_GE       = 7'd15;
    localparam logic [KindBits-1:0] K_PLUS     = 7'd16;
    localparam logic [KindBits-1:0] K_MINUS    = 7'd17;
    localparam logic [KindBits-1:0] K_STAR     = 7'd18;
    localparam logic [KindBits-1:0] K_SLASH    = 7'd19;
    localparam logic [KindBits-1:0] K_PERCENT  = 7'd20;
    localparam logic [KindBits-1:0] K_BANG     = 7'd21;
    localparam logic [KindBits-1:0] K_AMP      = 7'd22;
    localparam logic [KindBits-1:0] K_PIPE     = 7'd23;
    localparam logic [KindBits-1:0] K_CARET    = 7'd24;
    localparam logic [KindBits-1:0] K_SHL      = 7'd25;
    localparam logic [KindBits-1:0] K_SHR      = 7'd26;
    localparam logic [KindBits-1:0] K_DOT      = 7'd27;
    localparam logic [KindBits-1:0] K_DOTDOT   = 7'd28;
    localparam logic [KindBits-1:0] K_DOTDOTEQ = 7'd29;
    localparam logic [KindBits-1:0] K_ARROW    = 7'd30;
    localparam logic [KindBits-1:0] K_COLON    = 7'd32;
    localparam logic [KindBits-1:0] K_SEMI     = 7'd33;
    localparam logic [KindBits-1:0] K_COMMA    = 7'd34;
    localparam logic [KindBits-1:0] K_LPAREN   = 7'd35;
    localparam logic [KindBits-1:0] K_RPAREN   = 7'd36;
    localparam logic [KindBits-1:0] K_LBRACE   = 7'd37;
    localparam logic [KindBits-1:0] K_RBRACE   = 7'd38;
    localparam logic [KindBits-1:0] K_LBRACK   = 7'd39;
    localparam logic [KindBits-1:0] K_RBRACK   = 7'd40;
    localparam logic [KindBits-1:0] K_DOLLAR   = 7'd41;
    localparam logic [KindBits-1:0] K_QUEST    = 7'd42;
    localparam logic [KindBits-1:0] K_HASH     = 7'd43;
    localparam logic [KindBits-1:0] K_KW_BASE  = 7'd44;
    localparam logic [KindBits-1:0] K_ILLEGAL  = 7'd67;

    // scan modes
    localparam logic [ModeBits-1:0] M_IDLE        = 5'd0;
    localparam logic [ModeBits-1:0] M_SLASH       = 5'd1;
    localparam logic [ModeBits-1:0] M_LINE        = 5'd2;
    localparam logic [ModeBits-1:0] M_BLOCK       = 5'd3;
    localparam logic [ModeBits-1:0] M_BLOCK_SLASH = 5'd4;
    localparam logic [ModeBits-1:0] M_BLOCK_STAR  = 5'd5;
    localparam logic [ModeBits-1:0] M_MINUS       = 5'd6;
    localparam logic [ModeBits-1:0] M_BANG        = 5'd7;
    localparam logic [ModeBits-1:0] M_EQ          = 5'd8;
    localparam logic [ModeBits-1:0] M_LT          = 5'd9;
    localparam logic [ModeBits-1:0] M_GT          = 5'd10;
    localparam logic [ModeBits-1:0] M_COLON       = 5'd11;
    localparam logic [ModeBits-1:0] M_DOT         = 5'd12;
    localparam logic [ModeBits-1:0] M_DOTDOT      = 5'd13;
    localparam logic [ModeBits-1:0] M_STR         = 5'd14;
    localparam logic [ModeBits-1:0] M_STR_ESC     = 5'd15;
    localparam logic [ModeBits-1:0] M_CHR         = 5'd16;
    localparam logic [ModeBits-1:0] M_CHR_ESC     = 5'd17;
    localparam logic [ModeBits-1:0] M_CHR_CLOSE   = 5'd18;
    localparam logic [ModeBits-1:0] M_INT         = 5'd19;
    localparam logic [ModeBits-1:0] M_NDOT        = 5'd20;
    localparam logic [ModeBits-1:0] M_FRAC        = 5'd21;
    localparam logic [ModeBits-1:0] M_ESIGN       = 5'd22;
    localparam logic [ModeBits-1:0] M_EXP         = 5'd23;
    localparam logic [ModeBits-1:0] M_HEX         = 5'd24;
    localparam logic [ModeBits-1:0] M_BIN         = 5'd25;
    localparam logic [ModeBits-1:0] M_IDENT       = 5'd26;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        logic [KindBits-1:0]   kind;
        logic [OffsetBits-1:0] start_offset;
        logic [OffsetBits-1:0] length;
        logic [LineBits-1:0]   line;
        logic [ColumnBits-1:0] column;
        logic                  last;
    } out_beat_t;

    typedef struct packed {
        logic [KindBits-1:0]   kind;
        logic [OffsetBits-1:0] start_offset;
        logic [OffsetBits-1:0] length;
        logic [LineBits-1:0]   line;
        logic [ColumnBits-1:0] column;
    } tok_t;

    // up to three tokens classified from one input beat
    typedef struct packed {
        logic [1:0] count;
        tok_t       t0;
        tok_t       t1;
        tok_t       t2;
    } group_t;

    localparam int NumKw = 23;
    typedef logic [PrefixBits-1:0] kw_word_t;

    function automatic kw_word_t kw_word(input int i);
        unique case (i)
            0:  kw_word = 64'h0000_7374_7275_6374;
            1:  kw_word = 64'h0000_0000_656e_756d;
            2:  kw_word = 64'h0000_0075_6e69_6f6e;
            3:  kw_word = 64'h0000_0000_636f_6d70;
            4:  kw_word = 64'h0000_0075_7369_6e67;
            5:  kw_word = 64'h6469_7374_696e_6374;
            6:  kw_word = 64'h0000_0074_7261_6974;
            7:  kw_word = 64'h0000_0000_696d_706c;
            8:  kw_word = 64'h0000_0064_6566_6572;
            9:  kw_word = 64'h0000_0000_0000_6173;
            10: kw_word = 64'h0000_006d_6174_6368;
            11: kw_word = 64'h0000_0000_0000_6966;
            12: kw_word = 64'h0000_0000_656c_7365;
            13: kw_word = 64'h0000_0000_0066_6f72;
            14: kw_word = 64'h0000_0000_0000_696e;
            15: kw_word = 64'h0000_7265_7475_726e;
            16: kw_word = 64'h0000_0000_7472_7565;
            17: kw_word = 64'h0000_0066_616c_7365;
            18: kw_word = 64'h0000_0000_6e75_6c6c;
            19: kw_word = 64'h0000_0000_766f_6964;
            20: kw_word = 64'h0000_006e_6576_6572;
            21: kw_word = 64'h0000_006d_6179_6265;
            22: kw_word = 64'h0000_0000_7479_7065;
            default: kw_word = '0;
        endcase
    endfunction

    function automatic logic [3:0] kw_len(input int i);
        unique case (i)
            9, 11, 14:                      kw_len = 4'd2;
            13:                             kw_len = 4'd3;
            1, 3, 7, 12, 16, 18, 19, 22:    kw_len = 4'd4;
            2, 4, 6, 8, 10, 17, 20, 21:     kw_len = 4'd5;
            0, 15:                          kw_len = 4'd6;
            5:                              kw_len = 4'd8;
            default:                        kw_len = 4'd0;
        endcase
    endfunction

endpackage

@@ hdl/stt_front.sv @@
// ----------------------------------------------------------------------------
// stt_front: byte classifier and scanner state
// Consumes one byte per beat and forms a group of zero to three tokens.
// ----------------------------------------------------------------------------
module stt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  stt_pkg::in_beat_t   in_beat,
    input  logic                take,
    output stt_pkg::group_t     grp
);

    logic [stt_pkg::ModeBits-1:0]   mode_reg;
    logic [stt_pkg::OffsetBits-1:0] tstart_reg;
    logic [stt_pkg::OffsetBits-1:0] pos_reg;
    logic [stt_pkg::LineBits-1:0]   lcnt_reg;
    logic [stt_pkg::ColumnBits-1:0] ccnt_reg;
    logic [stt_pkg::LineBits-1:0]   sline_reg;
    logic [stt_pkg::ColumnBits-1:0] scol_reg;
    logic [stt_pkg::PrefixBits-1:0] prefix_reg;
    logic [stt_pkg::DepthBits-1:0]  depth_reg;

    logic [stt_pkg::ModeBits-1:0]   mode_next;
    logic [stt_pkg::OffsetBits-1:0] tstart_next;
    logic [stt_pkg::OffsetBits-1:0] pos_next;
    logic [stt_pkg::LineBits-1:0]   lcnt_next;
    logic [stt_pkg::ColumnBits-1:0] ccnt_next;
    logic [stt_pkg::LineBits-1:0]   sline_next;
    logic [stt_pkg::ColumnBits-1:0] scol_next;
    logic [stt_pkg::PrefixBits-1:0] prefix_next;
    logic [stt_pkg::DepthBits-1:0]  depth_next;

    logic [stt_pkg::OffsetBits-1:0] pos_inc;
    logic [stt_pkg::OffsetBits-1:0] wlen;
    logic [stt_pkg::KindBits-1:0]   word_kind;

    assign pos_inc = (pos_reg == stt_pkg::OFF_MAX) ? pos_reg : pos_reg + 1'b1;
    assign wlen    = pos_reg - tstart_reg;

    always_comb
    begin
        word_kind = stt_pkg::K_IDENT;
        if (pos_reg >= tstart_reg && wlen <= stt_pkg::OffsetBits'(stt_pkg::KeywordLen)
            && wlen <= stt_pkg::OffsetBits'(8))
        begin
            for (int i = 0; i < stt_pkg::NumKw; i++)
            begin
                if (wlen == stt_pkg::OffsetBits'(stt_pkg::kw_len(i))
                    && prefix_reg == stt_pkg::kw_word(i))
                begin
                    word_kind = stt_pkg::K_KW_BASE + stt_pkg::KindBits'(i);
                end
            end
        end
    end

    function automatic logic is_dig(input logic [7:0] c);
        is_dig = c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_alp(input logic [7:0] c);
        is_alp = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction
    function automatic logic is_hx(input logic [7:0] c);
        is_hx = is_dig(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    // the scanner state is walked through up to three passes per byte
    always_comb
    begin
        logic [7:0] c;
        logic again;
        logic incl;
        logic cls;
        logic [stt_pkg::KindBits-1:0] ck;
        logic [stt_pkg::OffsetBits-1:0] endp;
        logic [stt_pkg::OffsetBits-1:0] dotp;
        stt_pkg::tok_t t;
        stt_pkg::tok_t toks [3];
        logic [1:0] n;

        c = in_beat.ch;
        mode_next   = mode_reg;
        tstart_next = tstart_reg;
        pos_next    = pos_reg;
        lcnt_next   = lcnt_reg;
        ccnt_next   = ccnt_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        prefix_next = prefix_reg;
        depth_next  = depth_reg;
        toks[0] = '0;
        toks[1] = '0;
        toks[2] = '0;
        n = 2'd0;
        again = 1'b0;
        incl = 1'b0;
        cls = 1'b0;
        ck = '0;
        endp = '0;
        dotp = '0;
        t = '0;

        if (in_beat.end_of_input)
        begin
            cls = 1'b1;
            incl = 1'b0;
            unique case (mode_reg)
                stt_pkg::M_SLASH:  ck = stt_pkg::K_SLASH;
                stt_pkg::M_MINUS:  ck = stt_pkg::K_MINUS;
                stt_pkg::M_BANG:   ck = stt_pkg::K_BANG;
                stt_pkg::M_EQ:     ck = stt_pkg::K_EQ;
                stt_pkg::M_LT:     ck = stt_pkg::K_LT;
                stt_pkg::M_GT:     ck = stt_pkg::K_GT;
                stt_pkg::M_COLON:  ck = stt_pkg::K_COLON;
                stt_pkg::M_DOT:    ck = stt_pkg::K_DOT;
                stt_pkg::M_DOTDOT: ck = stt_pkg::K_DOTDOT;
                stt_pkg::M_STR, stt_pkg::M_STR_ESC, stt_pkg::M_CHR, stt_pkg::M_CHR_ESC,
                stt_pkg::M_CHR_CLOSE: ck = stt_pkg::K_ILLEGAL;
                stt_pkg::M_INT, stt_pkg::M_HEX, stt_pkg::M_BIN: ck = stt_pkg::K_INT;
                stt_pkg::M_FRAC, stt_pkg::M_ESIGN, stt_pkg::M_EXP: ck = stt_pkg::K_FLOAT;
                stt_pkg::M_IDENT:  ck = word_kind;
                default:           cls = 1'b0;
            endcase
            if (mode_reg == stt_pkg::M_NDOT)
            begin
                dotp = (pos_reg > 0) ? pos_reg - 1'b1 : '0;
                toks[0].kind = stt_pkg::K_INT;
                toks[0].start_offset = tstart_reg;
                toks[0].length = (dotp >= tstart_reg) ? dotp - tstart_reg : '0;
                toks[0].line = sline_reg;
                toks[0].column = scol_reg;
                toks[1].kind = stt_pkg::K_DOT;
                toks[1].start_offset = dotp;
                toks[1].length = (pos_reg >= dotp) ? pos_reg - dotp : '0;
                toks[1].line = lcnt_reg;
                toks[1].column = (ccnt_reg > 1) ? ccnt_reg - 1'b1 : stt_pkg::ColumnBits'(1);
                n = 2'd2;
            end
            else if (cls)
            begin
                toks[0].kind = ck;
                toks[0].start_offset = tstart_reg;
                toks[0].length = (pos_reg >= tstart_reg) ? pos_reg - tstart_reg : '0;
                toks[0].line = sline_reg;
                toks[0].column = scol_reg;
                n = 2'd1;
            end
            t.kind = stt_pkg::K_EOF;
            t.start_offset = pos_reg;
            t.length = '0;
            t.line = lcnt_reg;
            t.column = ccnt_reg;
            toks[n] = t;
            n = n + 2'd1;
            mode_next   = stt_pkg::M_IDLE;
            tstart_next = '0;
            pos_next    = '0;
            lcnt_next   = stt_pkg::LineBits'(1);
            ccnt_next   = stt_pkg::ColumnBits'(1);
            sline_next  = stt_pkg::LineBits'(1);
            scol_next   = stt_pkg::ColumnBits'(1);
            prefix_next = '0;
            depth_next  = '0;
        end
        else
        begin
            again = 1'b1;
            for (int p = 0; p < 3; p++)
            begin
                if (again)
                begin
                    again = 1'b0;
                    cls = 1'b0;
                    incl = 1'b0;
                    ck = '0;
                    unique case (mode_next)
                        stt_pkg::M_IDLE:
                        begin
                            if (!(c == 8'h20 || c == 8'h09 || c == 8'h0a))
                            begin
                                tstart_next = pos_reg;
                                sline_next = lcnt_reg;
                                scol_next = ccnt_reg;
                                incl = 1'b1;
                                cls = 1'b1;
                                unique case (c)
                                    8'h28: ck = stt_pkg::K_LPAREN;
                                    8'h29: ck = stt_pkg::K_RPAREN;
                                    8'h7b: ck = stt_pkg::K_LBRACE;
                                    8'h7d: ck = stt_pkg::K_RBRACE;
                                    8'h5b: ck = stt_pkg::K_LBRACK;
                                    8'h5d: ck = stt_pkg::K_RBRACK;
                                    8'h2c: ck = stt_pkg::K_COMMA;
                                    8'h3b: ck = stt_pkg::K_SEMI;
                                    8'h24: ck = stt_pkg::K_DOLLAR;
                                    8'h3f: ck = stt_pkg::K_QUEST;
                                    8'h23: ck = stt_pkg::K_HASH;
                                    8'h2b: ck = stt_pkg::K_PLUS;
                                    8'h2a: ck = stt_pkg::K_STAR;
                                    8'h25: ck = stt_pkg::K_PERCENT;
                                    8'h26: ck = stt_pkg::K_AMP;
                                    8'h7c: ck = stt_pkg::K_PIPE;
                                    8'h5e: ck = stt_pkg::K_CARET;
                                    8'h2d: begin cls = 1'b0; mode_next = stt_pkg::M_MINUS; end
                                    8'h21: begin cls = 1'b0; mode_next = stt_pkg::M_BANG; end
                                    8'h3d: begin cls = 1'b0; mode_next = stt_pkg::M_EQ; end
                                    8'h3c: begin cls = 1'b0; mode_next = stt_pkg::M_LT; end
                                    8'h3e: begin cls = 1'b0; mode_next = stt_pkg::M_GT; end
                                    8'h3a: begin cls = 1'b0; mode_next = stt_pkg::M_COLON; end
                                    8'h2e: begin cls = 1'b0; mode_next = stt_pkg::M_DOT; end
                                    8'h2f: begin cls = 1'b0; mode_next = stt_pkg::M_SLASH; end
                                    8'h27: begin cls = 1'b0; mode_next = stt_pkg::M_CHR; end
                                    8'h22: begin cls = 1'b0; mode_next = stt_pkg::M_STR; end
                                    default:
                                    begin
                                        prefix_next = stt_pkg::PrefixBits'(c);
                                        if (is_dig(c))
                                        begin
                                            cls = 1'b0;
                                            mode_next = stt_pkg::M_INT;
                                        end
                                        else if (is_alp(c) || c == 8'h5f)
                                        begin
                                            cls = 1'b0;
                                            mode_next = stt_pkg::M_IDENT;
                                        end
                                        else
                                        begin
                                            ck = stt_pkg::K_ILLEGAL;
                                        end
                                    end
                                endcase
                            end
                        end
                        stt_pkg::M_SLASH:
                        begin
                            if (c == 8'h2f)
                                mode_next = stt_pkg::M_LINE;
                            else if (c == 8'h2a)
                            begin
                                depth_next = stt_pkg::DepthBits'(1);
                                mode_next = stt_pkg::M_BLOCK;
                            end
                            else
                            begin
                                cls = 1'b1;
                                ck = stt_pkg::K_SLASH;
                            end
                        end
                        stt_pkg::M_LINE:
                        begin
                            if (c == 8'h0a)
                                mode_next = stt_pkg::M_IDLE;
                        end
                        stt_pkg::M_BLOCK, stt_pkg::M_BLOCK_SLASH, stt_pkg::M_BLOCK_STAR:
                        begin
                            if (mode_next == stt_pkg::M_BLOCK_SLASH && c == 8'h2a)
                            begin
                                if (depth_next < stt_pkg::DepthBits'(stt_pkg::NestMax))
                                    depth_next = depth_next + 1'b1;
                                mode_next = stt_pkg::M_BLOCK;
                            end
                            else if (mode_next == stt_pkg::M_BLOCK_STAR && c == 8'h2f)
                            begin
                                if (depth_next > 0)
                                    depth_next = depth_next - 1'b1;
                                mode_next = (depth_next == 0) ? stt_pkg::M_IDLE
                                                              : stt_pkg::M_BLOCK;
                            end
                            else if (c == 8'h2f)
                                mode_next = stt_pkg::M_BLOCK_SLASH;
                            else if (c == 8'h2a)
                                mode_next = stt_pkg::M_BLOCK_STAR;
                            else
                                mode_next = stt_pkg::M_BLOCK;
                        end
                        stt_pkg::M_MINUS:
                        begin
                            cls = 1'b1;
                            incl = c == 8'h3e;
                            ck = incl ? stt_pkg::K_ARROW : stt_pkg::K_MINUS;
                        end
                        stt_pkg::M_BANG:
                        begin
                            cls = 1'b1;
                            incl = c == 8'h3d;
                            ck = incl ? stt_pkg::K_NE : stt_pkg::K_BANG;
                        end
                        stt_pkg::M_EQ:
                        begin
                            cls = 1'b1;
                            incl = c == 8'h3d;
                            ck = incl ? stt_pkg::K_EQEQ : stt_pkg::K_EQ;
                        end
                        stt_pkg::M_LT:
                        begin
                            cls = 1'b1;
                            incl = c == 8'h3c || c == 8'h3d;
                            ck = (c == 8'h3c) ? stt_pkg::K_SHL
                               : (c == 8'h3d) ? stt_pkg::K_LE : stt_pkg::K_LT;
                        end
                        stt_pkg::M_GT:
                        begin
                            cls = 1'b1;
                            incl = c == 8'h3e || c == 8'h3d;
                            ck = (c == 8'h3e) ? stt_pkg::K_SHR
                               : (c == 8'h3d) ? stt_pkg::K_GE : stt_pkg::K_GT;
                        end
                        stt_pkg::M_COLON:
                        begin
                            cls = 1'b1;
                            incl = c == 8'h3a || c == 8'h3d;
                            ck = (c == 8'h3a) ? stt_pkg::K_CASSIGN
                               : (c == 8'h3d) ? stt_pkg::K_ASSIGN : stt_pkg::K_COLON;
                        end
                        stt_pkg::M_DOTDOT:
                        begin
                            cls = 1'b1;
                            incl = c == 8'h3d;
                            ck = incl ? stt_pkg::K_DOTDOTEQ : stt_pkg::K_DOTDOT;
                        end
                        stt_pkg::M_DOT:
                        begin
                            if (c == 8'h2e)
                                mode_next = stt_pkg::M_DOTDOT;
                            else
                            begin
                                cls = 1'b1;
                                ck = stt_pkg::K_DOT;
                            end
                        end
                        stt_pkg::M_STR:
                        begin
                            if (c == 8'h22)
                            begin
                                cls = 1'b1;
                                incl = 1'b1;
                                ck = stt_pkg::K_STRING;
                            end
                            else if (c == 8'h5c)
                                mode_next = stt_pkg::M_STR_ESC;
                        end
                        stt_pkg::M_STR_ESC: mode_next = stt_pkg::M_STR;
                        stt_pkg::M_CHR:
                            mode_next = (c == 8'h5c) ? stt_pkg::M_CHR_ESC
                                                     : stt_pkg::M_CHR_CLOSE;
                        stt_pkg::M_CHR_ESC: mode_next = stt_pkg::M_CHR_CLOSE;
                        stt_pkg::M_CHR_CLOSE:
                        begin
                            cls = 1'b1;
                            incl = c == 8'h27;
                            ck = incl ? stt_pkg::K_CHAR : stt_pkg::K_ILLEGAL;
                        end
                        stt_pkg::M_INT:
                        begin
                            if (is_dig(c))
                                mode_next = stt_pkg::M_INT;
                            else if (c == 8'h2e)
                                mode_next = stt_pkg::M_NDOT;
                            else if (c == 8'h65 || c == 8'h45)
                                mode_next = stt_pkg::M_ESIGN;
                            else if (wlen == stt_pkg::OffsetBits'(1)
                                     && prefix_next == stt_pkg::PrefixBits'(8'h30)
                                     && (c == 8'h78 || c == 8'h58))
                                mode_next = stt_pkg::M_HEX;
                            else if (wlen == stt_pkg::OffsetBits'(1)
                                     && prefix_next == stt_pkg::PrefixBits'(8'h30)
                                     && (c == 8'h62 || c == 8'h42))
                                mode_next = stt_pkg::M_BIN;
                            else
                            begin
                                cls = 1'b1;
                                ck = stt_pkg::K_INT;
                            end
                        end
                        stt_pkg::M_NDOT:
                        begin
                            if (is_dig(c))
                                mode_next = stt_pkg::M_FRAC;
                            else
                            begin
                                dotp = (pos_reg > 0) ? pos_reg - 1'b1 : '0;
                                t.kind = stt_pkg::K_INT;
                                t.start_offset = tstart_next;
                                t.length = (dotp >= tstart_next) ? dotp - tstart_next : '0;
                                t.line = sline_next;
                                t.column = scol_next;
                                toks[n] = t;
                                n = n + 2'd1;
                                tstart_next = dotp;
                                sline_next = lcnt_reg;
                                scol_next = (ccnt_reg > 1) ? ccnt_reg - 1'b1
                                                           : stt_pkg::ColumnBits'(1);
                                mode_next = stt_pkg::M_DOT;
                                again = 1'b1;
                            end
                        end
                        stt_pkg::M_FRAC:
                        begin
                            if (c == 8'h65 || c == 8'h45)
                                mode_next = stt_pkg::M_ESIGN;
                            else if (!is_dig(c))
                            begin
                                cls = 1'b1;
                                ck = stt_pkg::K_FLOAT;
                            end
                        end
                        stt_pkg::M_ESIGN:
                        begin
                            if (c == 8'h2b || c == 8'h2d || is_dig(c))
                                mode_next = stt_pkg::M_EXP;
                            else
                            begin
                                cls = 1'b1;
                                ck = stt_pkg::K_FLOAT;
                            end
                        end
                        stt_pkg::M_EXP:
                        begin
                            if (!is_dig(c))
                            begin
                                cls = 1'b1;
                                ck = stt_pkg::K_FLOAT;
                            end
                        end
                        stt_pkg::M_HEX:
                        begin
                            if (!is_hx(c))
                            begin
                                cls = 1'b1;
                                ck = stt_pkg::K_INT;
                            end
                        end
                        stt_pkg::M_BIN:
                        begin
                            if (c != 8'h30 && c != 8'h31)
                            begin
                                cls = 1'b1;
                                ck = stt_pkg::K_INT;
                            end
                        end
                        stt_pkg::M_IDENT:
                        begin
                            if (is_alp(c) || is_dig(c) || c == 8'h5f)
                                prefix_next = {prefix_next[stt_pkg::PrefixBits-9:0], c};
                            else
                            begin
                                cls = 1'b1;
                                ck = word_kind;
                            end
                        end
                        default:
                        begin
                            mode_next = stt_pkg::M_IDLE;
                            again = 1'b1;
                        end
                    endcase
                    if (cls)
                    begin
                        endp = incl ? pos_inc : pos_reg;
                        t.kind = ck;
                        t.start_offset = tstart_next;
                        t.length = (endp >= tstart_next) ? endp - tstart_next : '0;
                        t.line = sline_next;
                        t.column = scol_next;
                        toks[n] = t;
                        n = n + 2'd1;
                        mode_next = stt_pkg::M_IDLE;
                        again = !incl;
                    end
                end
            end
            pos_next = pos_inc;
            if (c == 8'h0a)
            begin
                lcnt_next = (lcnt_reg == stt_pkg::LIN_MAX) ? lcnt_reg : lcnt_reg + 1'b1;
                ccnt_next = stt_pkg::ColumnBits'(1);
            end
            else
                ccnt_next = (ccnt_reg == stt_pkg::COL_MAX) ? ccnt_reg : ccnt_reg + 1'b1;
        end
        grp.count = n;
        grp.t0 = toks[0];
        grp.t1 = toks[1];
        grp.t2 = toks[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stt_pkg::M_IDLE;
            tstart_reg <= '0;
            pos_reg    <= '0;
            lcnt_reg   <= stt_pkg::LineBits'(1);
            ccnt_reg   <= stt_pkg::ColumnBits'(1);
            sline_reg  <= stt_pkg::LineBits'(1);
            scol_reg   <= stt_pkg::ColumnBits'(1);
            prefix_reg <= '0;
            depth_reg  <= '0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            tstart_reg <= tstart_next;
            pos_reg    <= pos_next;
            lcnt_reg   <= lcnt_next;
            ccnt_reg   <= ccnt_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
            prefix_reg <= prefix_next;
            depth_reg  <= depth_next;
        end
    end

endmodule

@@ hdl/stt_queue.sv @@
// ----------------------------------------------------------------------------
// stt_queue: two-entry group queue between front and back
// Holds classified token groups so that both sides stall on their own.
// ----------------------------------------------------------------------------
module stt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  stt_pkg::group_t push_grp,
    input  logic            push,
    output logic            full,
    output stt_pkg::group_t head,
    output logic            nonempty,
    input  logic            pop
);

    stt_pkg::group_t slot_reg [2];
    logic            wr_reg;
    logic            rd_reg;
    logic [1:0]      cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign nonempty = cnt_reg != 2'd0;
    assign head     = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ hdl/stt_back.sv @@
// ----------------------------------------------------------------------------
// stt_back: token issue stage
// Walks each queued group one token per beat into the output register.
// ----------------------------------------------------------------------------
module stt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::group_t    head,
    input  logic               nonempty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output stt_pkg::out_beat_t out_beat
);

    logic [1:0]         idx_reg;
    logic [1:0]         idx_next;
    logic               vld_reg;
    stt_pkg::out_beat_t ob_reg;
    logic               load;
    logic               is_last;
    stt_pkg::tok_t      cur;

    assign load = nonempty && (head.count != 2'd0) && (!vld_reg || out_ready);
    assign is_last = (idx_reg + 2'd1) == head.count;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    cur = head.t0;
            2'd1:    cur = head.t1;
            default: cur = head.t2;
        endcase
    end

    assign pop = nonempty && ((head.count == 2'd0) || (load && is_last));
    assign idx_next = pop ? 2'd0 : (load ? idx_reg + 2'd1 : idx_reg);

    always_ff @(posedge clk)
    begin
        if (load)
            ob_reg <= {cur, is_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                vld_reg <= 1'b1;
            else if (out_ready)
                vld_reg <= 1'b0;
        end
    end

    assign out_valid = vld_reg;
    assign out_beat  = ob_reg;

endmodule

@@ hdl/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexer for source bytes
// channel | dir | payload
// in      | in  | in_beat  (ch, end_of_input)
// out     | out | out_beat (kind, start_offset, length, line, column, last)
// One byte per cycle enters while the two-entry group queue has room.
// A byte yielding k tokens issues them as k output beats; the queue absorbs
// bursts, so one byte per cycle is sustained with sparse tokens and no stall.
// Reset clears scan state and queue; no clearing pass.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  stt_pkg::in_beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output stt_pkg::out_beat_t out_beat
);

    stt_pkg::group_t grp;
    stt_pkg::group_t head;
    logic            full;
    logic            nonempty;
    logic            pop;
    logic            take;

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    stt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_beat (in_beat),
        .take    (take),
        .grp     (grp)
    );

    stt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_grp (grp),
        .push     (take),
        .full     (full),
        .head     (head),
        .nonempty (nonempty),
        .pop      (pop)
    );

    stt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .nonempty  (nonempty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

`ifndef SYNTH
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_beat.kind == stt_pkg::K_EOF |-> out_beat.last)
        else $error("eof beat without last");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !take)
        else $error("queue pushed while full");
`endif

endmodule

@@ verif/source_text_tokenizer_checker.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker: token predictor and scoreboard
// Watches both channels, predicts the tokens of every accepted input beat
// and compares each output beat field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module source_text_tokenizer_checker
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_beat_t  in_beat,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_beat_t out_beat,
    output int        fail_count,
    output int        pending_tokens,
    output int        token_total,
    output int        eof_total
);
    timeunit 1ns;
    timeprecision 1ps;

    out_beat_t expected_tokens[$];

    logic [ModeBits-1:0]   mode;
    logic [OffsetBits-1:0] tok_start, pos;
    logic [LineBits-1:0]   line_no, tok_line;
    logic [ColumnBits-1:0] col_no, tok_col;
    logic [63:0]           prefix;
    logic [DepthBits-1:0]  depth;
    int                    emitted;

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alp(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_hexd(logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    task automatic clear_scan();
        mode = M_IDLE;
        tok_start = '0;
        pos = '0;
        line_no = LineBits'(1);
        col_no = ColumnBits'(1);
        tok_line = LineBits'(1);
        tok_col = ColumnBits'(1);
        prefix = '0;
        depth = '0;
    endtask

    function automatic void push_token(logic [KindBits-1:0] k, logic [OffsetBits-1:0] s,
                                       logic [OffsetBits-1:0] n, logic [LineBits-1:0] l,
                                       logic [ColumnBits-1:0] c);
        out_beat_t t;
        if (emitted >= 3)
            return;
        t.kind = k;
        t.start_offset = s;
        t.length = n;
        t.line = l;
        t.column = c;
        t.last = 1'b0;
        expected_tokens.push_back(t);
        emitted++;
    endfunction

    // emits the pending token; returns 1 when the byte must be rescanned
    function automatic bit close_token(logic [KindBits-1:0] k, bit incl);
        logic [OffsetBits-1:0] stop;
        stop = incl ? ((pos == OFF_MAX) ? pos : pos + 1'b1) : pos;
        push_token(k, tok_start, (stop >= tok_start) ? stop - tok_start : '0,
                   tok_line, tok_col);
        mode = M_IDLE;
        return !incl;
    endfunction

    function automatic logic [KindBits-1:0] word_class();
        logic [OffsetBits-1:0] n;
        logic [63:0] w;
        string kw[23];
        n = pos - tok_start;
        kw = '{"struct", "enum", "union", "comp", "using", "distinct", "trait",
               "impl", "defer", "as", "match", "if", "else", "for", "in",
               "return", "true", "false", "null", "void", "never", "maybe",
               "type"};
        if (pos < tok_start || n > KeywordLen || n > 8)
            return K_IDENT;
        for (int i = 0; i < 23; i++)
        begin
            w = '0;
            for (int j = 0; j < kw[i].len(); j++)
                w = {w[55:0], kw[i][j]};
            if (kw[i].len() == n && w == prefix)
                return K_KW_BASE + i[KindBits-1:0];
        end
        return K_IDENT;
    endfunction

    task automatic split_int_dot();
        logic [OffsetBits-1:0] dot;
        dot = (pos > 0) ? pos - 1'b1 : '0;
        push_token(K_INT, tok_start, (dot >= tok_start) ? dot - tok_start : '0,
                   tok_line, tok_col);
        tok_start = dot;
        tok_line = line_no;
        tok_col = (col_no > 1) ? col_no - 1'b1 : ColumnBits'(1);
        mode = M_DOT;
    endtask

    function automatic bit two_char(logic [7:0] c, logic [7:0] a, logic [KindBits-1:0] ka,
                                    int b, logic [KindBits-1:0] kb,
                                    logic [KindBits-1:0] k0);
        if (c == a)
            return close_token(ka, 1);
        if (b >= 0 && c == b[7:0])
            return close_token(kb, 1);
        return close_token(k0, 0);
    endfunction

    function automatic logic [ModeBits-1:0] block_next(logic [7:0] c);
        return (c == "/") ? M_BLOCK_SLASH : (c == "*") ? M_BLOCK_STAR : M_BLOCK;
    endfunction

    task automatic start_token(logic [7:0] c);
        bit dummy;
        if (c == " " || c == 8'h09 || c == 8'h0a)
            return;
        tok_start = pos;
        tok_line = line_no;
        tok_col = col_no;
        case (c)
            "(": dummy = close_token(K_LPAREN, 1);
            ")": dummy = close_token(K_RPAREN, 1);
            "{": dummy = close_token(K_LBRACE, 1);
            "}": dummy = close_token(K_RBRACE, 1);
            "[": dummy = close_token(K_LBRACK, 1);
            "]": dummy = close_token(K_RBRACK, 1);
            ",": dummy = close_token(K_COMMA, 1);
            ";": dummy = close_token(K_SEMI, 1);
            "$": dummy = close_token(K_DOLLAR, 1);
            "?": dummy = close_token(K_QUEST, 1);
            "#": dummy = close_token(K_HASH, 1);
            "+": dummy = close_token(K_PLUS, 1);
            "*": dummy = close_token(K_STAR, 1);
            "%": dummy = close_token(K_PERCENT, 1);
            "&": dummy = close_token(K_AMP, 1);
            "|": dummy = close_token(K_PIPE, 1);
            "^": dummy = close_token(K_CARET, 1);
            "-": mode = M_MINUS;
            "!": mode = M_BANG;
            "=": mode = M_EQ;
            "<": mode = M_LT;
            ">": mode = M_GT;
            ":": mode = M_COLON;
            ".": mode = M_DOT;
            "/": mode = M_SLASH;
            "'": mode = M_CHR;
            "\"": mode = M_STR;
            default:
            begin
                prefix = {56'd0, c};
                if (is_dig(c))
                    mode = M_INT;
                else if (is_alp(c) || c == "_")
                    mode = M_IDENT;
                else
                    dummy = close_token(K_ILLEGAL, 1);
            end
        endcase
    endtask

    task automatic scan_byte(logic [7:0] c);
        bit again;
        bit dummy;
        again = 1;
        while (again)
        begin
            again = 0;
            case (mode)
                M_IDLE: start_token(c);
                M_SLASH:
                    if (c == "/")
                        mode = M_LINE;
                    else if (c == "*")
                    begin
                        depth = 1;
                        mode = M_BLOCK;
                    end
                    else
                        again = close_token(K_SLASH, 0);
                M_LINE: if (c == 8'h0a) mode = M_IDLE;
                M_BLOCK: mode = block_next(c);
                M_BLOCK_SLASH:
                    if (c == "*")
                    begin
                        if (depth < NestMax)
                            depth++;
                        mode = M_BLOCK;
                    end
                    else
                        mode = block_next(c);
                M_BLOCK_STAR:
                    if (c == "/")
                    begin
                        if (depth > 0)
                            depth--;
                        mode = (depth == 0) ? M_IDLE : M_BLOCK;
                    end
                    else
                        mode = block_next(c);
                M_MINUS:  again = two_char(c, ">", K_ARROW, -1, K_EOF, K_MINUS);
                M_BANG:   again = two_char(c, "=", K_NE, -1, K_EOF, K_BANG);
                M_EQ:     again = two_char(c, "=", K_EQEQ, -1, K_EOF, K_EQ);
                M_LT:     again = two_char(c, "<", K_SHL, "=", K_LE, K_LT);
                M_GT:     again = two_char(c, ">", K_SHR, "=", K_GE, K_GT);
                M_COLON:  again = two_char(c, ":", K_CASSIGN, "=", K_ASSIGN, K_COLON);
                M_DOTDOT: again = two_char(c, "=", K_DOTDOTEQ, -1, K_EOF, K_DOTDOT);
                M_DOT:
                    if (c == ".")
                        mode = M_DOTDOT;
                    else
                        again = close_token(K_DOT, 0);
                M_STR:
                    if (c == "\"")
                        dummy = close_token(K_STRING, 1);
                    else if (c == "\\")
                        mode = M_STR_ESC;
                M_STR_ESC: mode = M_STR;
                M_CHR: mode = (c == "\\") ? M_CHR_ESC : M_CHR_CLOSE;
                M_CHR_ESC: mode = M_CHR_CLOSE;
                M_CHR_CLOSE:
                    if (c == "'")
                        dummy = close_token(K_CHAR, 1);
                    else
                        again = close_token(K_ILLEGAL, 0);
                M_INT:
                    if (!is_dig(c))
                    begin
                        if (c == ".")
                            mode = M_NDOT;
                        else if (c == "e" || c == "E")
                            mode = M_ESIGN;
                        else if (pos - tok_start == 1 && prefix == "0"
                                 && (c == "x" || c == "X"))
                            mode = M_HEX;
                        else if (pos - tok_start == 1 && prefix == "0"
                                 && (c == "b" || c == "B"))
                            mode = M_BIN;
                        else
                            again = close_token(K_INT, 0);
                    end
                M_NDOT:
                    if (is_dig(c))
                        mode = M_FRAC;
                    else
                    begin
                        split_int_dot();
                        again = 1;
                    end
                M_FRAC:
                    if (!is_dig(c))
                    begin
                        if (c == "e" || c == "E")
                            mode = M_ESIGN;
                        else
                            again = close_token(K_FLOAT, 0);
                    end
                M_ESIGN:
                    if (c == "+" || c == "-" || is_dig(c))
                        mode = M_EXP;
                    else
                        again = close_token(K_FLOAT, 0);
                M_EXP: if (!is_dig(c)) again = close_token(K_FLOAT, 0);
                M_HEX: if (!is_hexd(c)) again = close_token(K_INT, 0);
                M_BIN: if (c != "0" && c != "1") again = close_token(K_INT, 0);
                M_IDENT:
                    if (is_alp(c) || is_dig(c) || c == "_")
                        prefix = {prefix[55:0], c};
                    else
                        again = close_token(word_class(), 0);
                default:
                begin
                    mode = M_IDLE;
                    again = 1;
                end
            endcase
        end
    endtask

    task automatic flush_pending();
        bit dummy;
        case (mode)
            M_SLASH:  dummy = close_token(K_SLASH, 0);
            M_MINUS:  dummy = close_token(K_MINUS, 0);
            M_BANG:   dummy = close_token(K_BANG, 0);
            M_EQ:     dummy = close_token(K_EQ, 0);
            M_LT:     dummy = close_token(K_LT, 0);
            M_GT:     dummy = close_token(K_GT, 0);
            M_COLON:  dummy = close_token(K_COLON, 0);
            M_DOT:    dummy = close_token(K_DOT, 0);
            M_DOTDOT: dummy = close_token(K_DOTDOT, 0);
            M_STR, M_STR_ESC, M_CHR, M_CHR_ESC, M_CHR_CLOSE:
                dummy = close_token(K_ILLEGAL, 0);
            M_INT, M_HEX, M_BIN: dummy = close_token(K_INT, 0);
            M_FRAC, M_ESIGN, M_EXP: dummy = close_token(K_FLOAT, 0);
            M_IDENT: dummy = close_token(word_class(), 0);
            M_NDOT:
            begin
                split_int_dot();
                dummy = close_token(K_DOT, 0);
            end
            default: ;
        endcase
    endtask

    task automatic predict_beat(in_beat_t b);
        emitted = 0;
        if (b.end_of_input)
        begin
            flush_pending();
            push_token(K_EOF, pos, '0, line_no, col_no);
            clear_scan();
        end
        else
        begin
            scan_byte(b.ch);
            if (pos != OFF_MAX)
                pos++;
            if (b.ch == 8'h0a)
            begin
                if (line_no != LIN_MAX)
                    line_no++;
                col_no = ColumnBits'(1);
            end
            else if (col_no != COL_MAX)
                col_no++;
        end
        if (emitted > 0)
            expected_tokens[$].last = 1'b1;
    endtask

    task automatic compare_token(out_beat_t got);
        out_beat_t want;
        if (expected_tokens.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected token beat: %p", got);
            return;
        end
        want = expected_tokens.pop_front();
        token_total++;
        if (got.kind == K_EOF)
            eof_total++;
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("token mismatch: expected %p, got %p", want, got);
        end
    endtask

    initial
    begin
        fail_count = 0;
        token_total = 0;
        eof_total = 0;
        clear_scan();
    end

    assign pending_tokens = expected_tokens.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                compare_token(out_beat);
            if (in_valid && in_ready)
                predict_beat(in_beat);
        end
    end

endmodule

@@ verif/source_text_tokenizer_tb.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_tb: stimulus and verdict for the tokenizer
// Feeds directed lexer cases, then random lexemes (some malformed) mixed with
// noise bytes, with random gaps and output stalls; the checker scores tokens.
// ----------------------------------------------------------------------------
module source_text_tokenizer_tb;
    import stt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_beat;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_beat;
    int        fail_count;
    int        pending_tokens;
    int        token_total;
    int        eof_total;
    bit        gaps_on;
    int        bytes_sent;

    source_text_tokenizer dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_beat(in_beat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_beat(out_beat)
    );

    source_text_tokenizer_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_beat(in_beat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_beat(out_beat),
        .fail_count(fail_count),
        .pending_tokens(pending_tokens),
        .token_total(token_total),
        .eof_total(eof_total)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(negedge clk)
    begin
        if (!gaps_on)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 20);
    end

    task automatic send_beat(logic [7:0] c, logic e);
        if (gaps_on)
            while ($urandom_range(99) < 20)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_beat <= '{ch: c, end_of_input: e};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    function automatic string random_lexeme();
        string pool[] = '{"struct", "enum", "union", "comp", "using", "distinct",
            "trait", "impl", "defer", "as", "match", "if", "else", "for", "in",
            "return", "true", "false", "null", "void", "never", "maybe", "type",
            "x_1", "Foo", "_a9", "distincts", "longidentifier", "0", "42",
            "3.14", "1e5", "2.5E-3", "7e+", "0x1fA", "0b101", "0b", "9..", "1.x",
            "\"str\\\"q\"", "\"a\\nb\"", "'c'", "'\\n'", "'ab", ":=", "::", ":",
            "==", "=", "!=", "!", "<=", "<<", "<", ">=", ">>", ">", "->", "-",
            "..=", "..", ".", "+", "*", "/", "%", "&", "|", "^", "(", ")", "{",
            "}", "[", "]", ",", ";", "$", "?", "#", "// note\n",
            "/* a /* b */ c */", "\n", "\t", " "};
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        out_ready = 1'b1;
        gaps_on = 1'b0;
        bytes_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: operators, numbers with a trailing dot, escapes, comments
        send_text("a:=1.5..=0x;'\\'' ");
        send_beat(8'h0d, 1'b0);
        send_beat(8'hff, 1'b0);
        send_text("9.e/*/**/*/\"");
        send_beat(8'h00, 1'b1);
        send_text("if 3.");
        send_beat(8'h80, 1'b1);
        send_text("/* open");
        send_beat(8'h55, 1'b1);

        gaps_on = 1'b1;
        while (bytes_sent < 275)
        begin
            if ($urandom_range(99) < 8)
                send_beat(8'($urandom_range(255)), 1'b0);
            else
                send_text(random_lexeme());
            if ($urandom_range(99) < 40)
                send_beat(8'h20, 1'b0);
            if ($urandom_range(99) < 4)
                send_beat(8'($urandom_range(255)), 1'b1);
            if (bytes_sent > 120 && bytes_sent < 170)
                gaps_on = 1'b0;
            else
                gaps_on = 1'b1;
        end
        send_beat(8'h00, 1'b1);
        in_valid <= 1'b0;

        while (pending_tokens != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("sent %0d input beats; checked %0d tokens including %0d end markers",
                 bytes_sent, token_total, eof_total);
        if (fail_count == 0)
            $display("source_text_tokenizer test passed");
        else
            $display("source_text_tokenizer test failed");
        $finish;
    end

    initial
    begin
        #200000;
        $display("source_text_tokenizer test failed");
        $finish;
    end

endmodule
